FILE: rtl/core/rhvp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPC header parser package
// Shared types, constants and the varint group placement function.
// ----------------------------------------------------------------------------
package rhvp_pkg;

    localparam logic [7:0] GROUP_MASK      = 8'h7f;
    localparam logic [7:0] MORE_FLAG       = 8'h80;
    localparam logic [7:0] NO_OBJECT_RESET = 8'hfe;

    // Number of 7-bit groups that still land inside a 64-bit accumulator.
    localparam int         GROUPS_64       = 10;
    localparam int         GROUP_IDX_W     = 4;

    localparam logic       STATUS_OK        = 1'b0;
    localparam logic       STATUS_TRUNCATED = 1'b1;

    typedef struct packed {
        logic [7:0]  service;
        logic [31:0] method;
        logic [15:0] request_id;
        logic [63:0] object_id;
        logic [31:0] data_size;
        logic [7:0]  header_length;
        logic        status;
    } t_result;

    // Places the low seven bits of a varint byte at group position k.
    // Bits past bit 63 are dropped, and groups beyond the tenth vanish.
    function automatic logic [63:0] place_group(input logic [7:0] b,
                                                input logic [GROUP_IDX_W-1:0] k);
        logic [63:0] g;
        logic [63:0] placed;
        g = {56'd0, b & GROUP_MASK};
        case (k)
            4'd0:    placed = g;
            4'd1:    placed = g << 7;
            4'd2:    placed = g << 14;
            4'd3:    placed = g << 21;
            4'd4:    placed = g << 28;
            4'd5:    placed = g << 35;
            4'd6:    placed = g << 42;
            4'd7:    placed = g << 49;
            4'd8:    placed = g << 56;
            4'd9:    placed = g << 63;
            default: placed = 64'd0;
        endcase
        return placed;
    endfunction

endpackage

FILE: rtl/core/rhvp_out_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPC header parser result buffer
// Output register with one skid entry, so the parser keeps taking bytes
// while a result waits for the downstream transfer.
// ----------------------------------------------------------------------------
module rhvp_out_skid
    import rhvp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    drain;

    // The main register may load when it is empty or its result leaves now.
    assign drain   = !r_main_valid || i_ready;
    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (drain) begin
            if (r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else if (i_push) begin
                r_main <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

FILE: rtl/core/rpc_header_varint_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPC header varint parser
// Latency: a result is on the output port in the cycle after the byte that
// completes or truncates the header is transferred in, if no result waits.
// Throughput: one byte per cycle while o_ready is high; single-pass update.
// Reset (synchronous, active low) returns to idle, empties the result buffer
// and sets the no-object service value to 0xfe.
// ----------------------------------------------------------------------------
//
// The parser walks a header of the form: service byte, method varint,
// request id (two bytes, little-endian), object id varint (absent when the
// service equals the configured no-object value) and payload size varint.
// Varints are base 128, low group first, with bit 7 set on all but the last
// byte. Groups that fall beyond a field's width are dropped, but their bytes
// still count toward the header length, which saturates at 255.
//
// A packet start always opens a new header and silently drops an unfinished
// one. When the size varint ends, one result with status ok is produced and
// the parser ignores bytes until the next packet start. If the packet ends
// before that, one result with status truncated is produced, carrying only
// the bytes consumed so far; all decoded fields read as zero.
//
// Results go through an output register backed by one skid entry; input
// ready drops only while that skid entry is occupied.
module rpc_header_varint_parser
    import rhvp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    // Byte input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_packet_start,
    input  logic        i_packet_end,
    // Result output channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_service,
    output logic [31:0] o_method,
    output logic [15:0] o_request_id,
    output logic [63:0] o_object_id,
    output logic [31:0] o_data_size,
    output logic [7:0]  o_header_length,
    output logic        o_status
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_METHOD,
        PH_REQ_LO,
        PH_REQ_HI,
        PH_OBJECT,
        PH_SIZE,
        PH_DONE
    } t_phase;

    logic [7:0]             r_no_object_service;
    t_phase                 r_phase,       n_phase;
    logic [GROUP_IDX_W-1:0] r_group_idx,   n_group_idx;
    logic [7:0]             r_service,     n_service;
    logic [31:0]            r_method,      n_method;
    logic [15:0]            r_request,     n_request;
    logic [63:0]            r_object,      n_object;
    logic [31:0]            r_size,        n_size;
    logic [7:0]             r_byte_count,  n_byte_count;

    logic                   accept;
    logic                   skid_full;
    logic                   complete;
    logic                   push;
    logic                   last_group;
    logic [63:0]            placed;
    logic [GROUP_IDX_W-1:0] group_step;
    t_result                result;
    t_result                out_data;

    assign o_ready = !skid_full;
    assign accept  = i_valid && o_ready;

    assign last_group = (i_data_byte & MORE_FLAG) == 8'd0;
    assign placed     = place_group(i_data_byte, r_group_idx);

    // The group index stops advancing once it passes the last 64-bit group.
    assign group_step = (r_group_idx < GROUP_IDX_W'(GROUPS_64))
                      ? r_group_idx + GROUP_IDX_W'(1) : r_group_idx;

    always_comb begin
        n_phase      = r_phase;
        n_group_idx  = r_group_idx;
        n_service    = r_service;
        n_method     = r_method;
        n_request    = r_request;
        n_object     = r_object;
        n_size       = r_size;
        n_byte_count = r_byte_count;
        complete     = 1'b0;
        push         = 1'b0;

        if (i_packet_start) begin
            // A new packet: the first byte is the service.
            n_group_idx  = '0;
            n_service    = i_data_byte;
            n_method     = '0;
            n_request    = '0;
            n_object     = '0;
            n_size       = '0;
            n_byte_count = 8'd1;
            n_phase      = PH_METHOD;
        end else if (r_phase == PH_IDLE || r_phase == PH_DONE) begin
            // Bytes outside a header are dropped; an end just rearms idle.
            if (i_packet_end) begin
                n_phase = PH_IDLE;
            end
        end else begin
            if (r_byte_count != 8'hff) begin
                n_byte_count = r_byte_count + 8'd1;
            end
            unique case (r_phase)
                PH_METHOD: begin
                    n_method    = r_method | placed[31:0];
                    n_group_idx = group_step;
                    if (last_group) begin
                        n_group_idx = '0;
                        n_phase     = PH_REQ_LO;
                    end
                end
                PH_REQ_LO: begin
                    n_request = {r_request[15:8], i_data_byte};
                    n_phase   = PH_REQ_HI;
                end
                PH_REQ_HI: begin
                    n_request   = {i_data_byte, r_request[7:0]};
                    n_group_idx = '0;
                    n_phase     = (r_service == r_no_object_service) ? PH_SIZE : PH_OBJECT;
                end
                PH_OBJECT: begin
                    n_object    = r_object | placed;
                    n_group_idx = group_step;
                    if (last_group) begin
                        n_group_idx = '0;
                        n_phase     = PH_SIZE;
                    end
                end
                PH_SIZE: begin
                    n_size      = r_size | placed[31:0];
                    n_group_idx = group_step;
                    if (last_group) begin
                        n_group_idx = '0;
                        complete    = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        // A header that completes on the last byte still reports ok.
        result.header_length = n_byte_count;
        if (complete) begin
            result.service    = n_service;
            result.method     = n_method;
            result.request_id = n_request;
            result.object_id  = n_object;
            result.data_size  = n_size;
            result.status     = STATUS_OK;
            n_phase           = i_packet_end ? PH_IDLE : PH_DONE;
            push              = 1'b1;
        end else begin
            result.service    = '0;
            result.method     = '0;
            result.request_id = '0;
            result.object_id  = '0;
            result.data_size  = '0;
            result.status     = STATUS_TRUNCATED;
            if (i_packet_end && n_phase != PH_IDLE) begin
                n_phase = PH_IDLE;
                push    = 1'b1;
            end
        end
    end

    // Truncation only reports when a header was actually open; an end seen
    // while idle or done leaves the phase at idle without a result.
    logic result_push;
    assign result_push = accept && push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_object_service <= NO_OBJECT_RESET;
            r_phase             <= PH_IDLE;
            r_group_idx         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_no_object_service <= i_cfg_wdata;
            end
            if (accept) begin
                r_phase     <= n_phase;
                r_group_idx <= n_group_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_service    <= n_service;
            r_method     <= n_method;
            r_request    <= n_request;
            r_object     <= n_object;
            r_size       <= n_size;
            r_byte_count <= n_byte_count;
        end
    end

    rhvp_out_skid u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (result_push),
        .i_data  (result),
        .o_full  (skid_full),
        .o_valid (o_valid),
        .o_data  (out_data),
        .i_ready (i_ready)
    );

    assign o_service       = out_data.service;
    assign o_method        = out_data.method;
    assign o_request_id    = out_data.request_id;
    assign o_object_id     = out_data.object_id;
    assign o_data_size     = out_data.data_size;
    assign o_header_length = out_data.header_length;
    assign o_status        = out_data.status;

endmodule
